### sv/scf_pkg.sv
// Package for the symmetric column FIR filter unit.
// Holds sizing constants, item structs and configuration register codes.
// No dependencies.
package scf_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HALF    = 7;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;

    localparam int RING_ROWS   = 2 * MAX_HALF;
    localparam int SLOT_BITS   = 4;
    localparam int COL_BITS    = 11;
    localparam int LW_BITS     = 12;
    localparam int HALF_BITS   = 3;
    localparam int ROWS_BITS   = 4;
    localparam int TAP_SLOTS   = 8;
    localparam int COEF_LANE   = 16;
    localparam int PAIR_BITS   = SAMPLE_BITS + 1;
    localparam int PROD_BITS   = PAIR_BITS + COEF_BITS;
    localparam int ACC_BITS    = 40;
    localparam int DELTA_BITS  = 32;
    localparam int CFG_DATA_BITS  = 64;
    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE,
        REG_HALF_TAPS,
        REG_LINE_WIDTH,
        REG_COEF_LOW,
        REG_COEF_HIGH,
        REG_DELTA_OFFSET
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] pixel_value;
        logic               frame_start;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] filtered_value;
        logic [COL_BITS-1:0]        out_column;
        logic                       row_last;
    } out_item_t;

endpackage

### sv/scf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module scf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

### sv/symmetric_column_fir_filter_unit.sv
// Top level of the symmetric column FIR filter unit.
// Depends on scf_pkg and on scf_ram for the fourteen row banks.
//
// Usage: pixels enter in raster order on the in channel (in_valid, in_stall,
// in_item); one item is taken at every edge where in_valid is high and in_stall
// low. Set frame_start on the first pixel of each frame. Results leave on the
// out channel (out_valid, out_stall, out_item), one per pixel once 2*H full
// rows of the frame precede the current row; other pixels give no result.
// Configuration is written through cfg_valid, cfg_index and cfg_data while the
// unit is idle; cfg_ready is always high.
// Throughput is one pixel per cycle while out_stall is low: each ring slot is
// its own row bank with one write and one read per cycle, all banks read at
// the same column. A result item passes stages 1 to 5 and the output register.
// When the receiver holds out_stall, the output register and the pipeline
// behind it fill, after which in_stall rises; nothing is lost.
// Reset clears the counters and loads the register defaults. The row banks are
// not cleared and need no clearing pass: a window is read only once 2*H rows of
// the current frame are complete, so its rows are set unless the width rose.
module symmetric_column_fir_filter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  scf_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output scf_pkg::out_item_t                    out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [scf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [scf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import scf_pkg::*;

    function automatic logic [SLOT_BITS-1:0] slot_back(input logic [SLOT_BITS-1:0] ws,
                                                       input logic [SLOT_BITS-1:0] d);
        logic [SLOT_BITS:0] t;
        t = {1'b0, ws} + (SLOT_BITS+1)'(RING_ROWS) - {1'b0, d};
        if (t >= (SLOT_BITS+1)'(RING_ROWS))
        begin
            t = t - (SLOT_BITS+1)'(RING_ROWS);
        end
        return t[SLOT_BITS-1:0];
    endfunction

    logic                         mode_reg;
    logic [HALF_BITS-1:0]         half_taps_reg;
    logic [LW_BITS-1:0]           line_width_reg;
    logic [CFG_DATA_BITS-1:0]     coef_low_reg;
    logic [CFG_DATA_BITS-1:0]     coef_high_reg;
    logic signed [DELTA_BITS-1:0] delta_reg;

    logic [COL_BITS-1:0]  col_cnt_reg, col_cnt_next;
    logic [ROWS_BITS-1:0] rows_filled_reg, rows_filled_next;
    logic [SLOT_BITS-1:0] slot_reg, slot_next;

    logic [LW_BITS-1:0]   w_eff;
    logic [LW_BITS-1:0]   col_ext;
    logic [COL_BITS-1:0]  cc, col;
    logic [ROWS_BITS-1:0] rf;
    logic [SLOT_BITS-1:0] ws;
    logic [HALF_BITS-1:0] h_eff;
    logic                 last;
    logic                 has_result;
    logic                 accept;

    logic adv1, adv2, adv3, adv4, adv5, adv_out;

    logic                          s1_v_reg;
    logic signed [SAMPLE_BITS-1:0] s1_pix_reg;
    logic [SLOT_BITS-1:0]          s1_ws_reg;
    logic [HALF_BITS-1:0]          s1_h_reg;
    logic [COL_BITS-1:0]           s1_col_reg;
    logic                          s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] bank_q [RING_ROWS];

    logic                        s2_v_reg;
    logic signed [PAIR_BITS-1:0] s2_pair_reg [TAP_SLOTS];
    logic signed [PAIR_BITS-1:0] s2_pair_next [TAP_SLOTS];
    logic [COL_BITS-1:0]         s2_col_reg;
    logic                        s2_last_reg;

    logic signed [COEF_BITS-1:0] coef_k [TAP_SLOTS];
    logic                        s3_v_reg;
    logic signed [PROD_BITS-1:0] s3_prod_reg [TAP_SLOTS];
    logic [COL_BITS-1:0]         s3_col_reg;
    logic                        s3_last_reg;

    logic                       s4_v_reg;
    logic signed [ACC_BITS-1:0] s4_sum_reg [TAP_SLOTS/2];
    logic [COL_BITS-1:0]        s4_col_reg;
    logic                       s4_last_reg;

    logic                       s5_v_reg;
    logic signed [ACC_BITS-1:0] s5_lo_reg, s5_hi_reg;
    logic [COL_BITS-1:0]        s5_col_reg;
    logic                       s5_last_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            half_taps_reg  <= HALF_BITS'(1);
            line_width_reg <= LW_BITS'(640);
            coef_low_reg   <= '0;
            coef_high_reg  <= '0;
            delta_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:         mode_reg       <= cfg_data[0];
                REG_HALF_TAPS:    half_taps_reg  <= cfg_data[HALF_BITS-1:0];
                REG_LINE_WIDTH:   line_width_reg <= cfg_data[LW_BITS-1:0];
                REG_COEF_LOW:     coef_low_reg   <= cfg_data;
                REG_COEF_HIGH:    coef_high_reg  <= cfg_data;
                REG_DELTA_OFFSET: delta_reg      <= cfg_data[DELTA_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Input stage: position in the frame, bank write and window read.
    always_comb
    begin
        if (line_width_reg == '0)
        begin
            w_eff = LW_BITS'(1);
        end
        else if (line_width_reg > LW_BITS'(MAX_WIDTH))
        begin
            w_eff = LW_BITS'(MAX_WIDTH);
        end
        else
        begin
            w_eff = line_width_reg;
        end
        h_eff = (half_taps_reg > HALF_BITS'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : half_taps_reg;

        cc = in_item.frame_start ? '0 : col_cnt_reg;
        rf = in_item.frame_start ? '0 : rows_filled_reg;
        ws = in_item.frame_start ? '0 : slot_reg;

        col_ext    = ({1'b0, cc} >= w_eff) ? (w_eff - LW_BITS'(1)) : {1'b0, cc};
        col        = col_ext[COL_BITS-1:0];
        last       = (col_ext == (w_eff - LW_BITS'(1)));
        has_result = (rf >= {1'b0, h_eff} + {1'b0, h_eff});

        if (last)
        begin
            col_cnt_next     = '0;
            slot_next        = (ws == SLOT_BITS'(RING_ROWS - 1)) ? '0 : ws + SLOT_BITS'(1);
            rows_filled_next = (rf < ROWS_BITS'(RING_ROWS)) ? rf + ROWS_BITS'(1) : rf;
        end
        else
        begin
            col_cnt_next     = col + COL_BITS'(1);
            slot_next        = ws;
            rows_filled_next = rf;
        end
    end

    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv5     = !s5_v_reg || adv_out;
    assign adv4     = !s4_v_reg || adv5;
    assign adv3     = !s3_v_reg || adv4;
    assign adv2     = !s2_v_reg || adv3;
    assign adv1     = !s1_v_reg || adv2;
    assign in_stall = !adv1;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg     <= '0;
            rows_filled_reg <= '0;
            slot_reg        <= '0;
        end
        else if (accept)
        begin
            col_cnt_reg     <= col_cnt_next;
            rows_filled_reg <= rows_filled_next;
            slot_reg        <= slot_next;
        end
    end

    for (genvar b = 0; b < RING_ROWS; b++)
    begin : g_bank
        scf_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_bank (
            .clk     (clk),
            .wr_en   (accept && (ws == SLOT_BITS'(b))),
            .wr_addr (col),
            .wr_data (in_item.pixel_value),
            .rd_en   (accept && has_result),
            .rd_addr (col),
            .rd_data (bank_q[b])
        );
    end

    // Stage 1 holds the item while the banks present their data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv1)
        begin
            s1_v_reg <= accept && has_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= in_item.pixel_value;
            s1_ws_reg   <= ws;
            s1_h_reg    <= h_eff;
            s1_col_reg  <= col;
            s1_last_reg <= last;
        end
    end

    // Stage 2: pick the window rows and form the tap pairs.
    always_comb
    begin
        logic signed [SAMPLE_BITS-1:0] centre;
        logic signed [SAMPLE_BITS-1:0] below;
        logic signed [SAMPLE_BITS-1:0] above;
        logic [SLOT_BITS-1:0]          h4;
        h4 = {1'b0, s1_h_reg};
        centre = (s1_h_reg == '0) ? s1_pix_reg : bank_q[slot_back(s1_ws_reg, h4)];
        s2_pair_next[0] = mode_reg ? '0 : PAIR_BITS'(centre);
        for (int k = 1; k < TAP_SLOTS; k++)
        begin
            below = (h4 == SLOT_BITS'(k)) ? s1_pix_reg
                                          : bank_q[slot_back(s1_ws_reg, h4 - SLOT_BITS'(k))];
            above = bank_q[slot_back(s1_ws_reg, h4 + SLOT_BITS'(k))];
            if (SLOT_BITS'(k) > h4)
            begin
                s2_pair_next[k] = '0;
            end
            else if (mode_reg)
            begin
                s2_pair_next[k] = PAIR_BITS'(below) - PAIR_BITS'(above);
            end
            else
            begin
                s2_pair_next[k] = PAIR_BITS'(below) + PAIR_BITS'(above);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv2)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && s1_v_reg)
        begin
            s2_pair_reg <= s2_pair_next;
            s2_col_reg  <= s1_col_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // Stage 3: one multiplier per tap.
    always_comb
    begin
        for (int k = 0; k < TAP_SLOTS; k++)
        begin
            if (k < TAP_SLOTS / 2)
            begin
                coef_k[k] = coef_low_reg[COEF_LANE*k +: COEF_BITS];
            end
            else
            begin
                coef_k[k] = coef_high_reg[COEF_LANE*(k - TAP_SLOTS/2) +: COEF_BITS];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv3)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && s2_v_reg)
        begin
            for (int k = 0; k < TAP_SLOTS; k++)
            begin
                s3_prod_reg[k] <= PROD_BITS'(coef_k[k]) * PROD_BITS'(s2_pair_reg[k]);
            end
            s3_col_reg  <= s2_col_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stages 4 and 5: adder tree with the offset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end
        else
        begin
            if (adv4)
            begin
                s4_v_reg <= s3_v_reg;
            end
            if (adv5)
            begin
                s5_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv4 && s3_v_reg)
        begin
            for (int i = 0; i < TAP_SLOTS / 2; i++)
            begin
                s4_sum_reg[i] <= ACC_BITS'(s3_prod_reg[2*i]) + ACC_BITS'(s3_prod_reg[2*i+1]);
            end
            s4_col_reg  <= s3_col_reg;
            s4_last_reg <= s3_last_reg;
        end
        if (adv5 && s4_v_reg)
        begin
            s5_lo_reg   <= s4_sum_reg[0] + s4_sum_reg[1];
            s5_hi_reg   <= s4_sum_reg[2] + s4_sum_reg[3] + ACC_BITS'(delta_reg);
            s5_col_reg  <= s4_col_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && s5_v_reg)
        begin
            out_item_reg.filtered_value <= s5_lo_reg + s5_hi_reg;
            out_item_reg.out_column     <= s5_col_reg;
            out_item_reg.row_last       <= s5_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Checks.
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_filled_reg <= ROWS_BITS'(RING_ROWS))
        else $error("rows_filled beyond ring size");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg < SLOT_BITS'(RING_ROWS))
        else $error("write slot beyond ring");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last |=> col_cnt_reg == $past(col) + COL_BITS'(1))
        else $error("column count did not step");

    a_result_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept && has_result |=> s1_v_reg)
        else $error("result item lost at pipeline entry");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for symmetric_column_fir_filter_unit: drives raster pixels and
// register writes, predicts every column filter result and checks each one as it leaves.
// Depends on scf_pkg and the unit's RTL only.
module testbench;
    import scf_pkg::*;

    localparam int PIXEL_TARGET = 1700;
    localparam int CYCLE_LIMIT  = 600000;

    class column_fir_checker;
        bit                 mode;
        logic [2:0]         half_taps;
        logic [11:0]        line_width;
        logic [63:0]        coef_lo;
        logic [63:0]        coef_hi;
        longint             delta;
        logic signed [15:0] row_ring [RING_ROWS][MAX_WIDTH];
        bit                 row_ring_set [RING_ROWS][MAX_WIDTH];
        int                 col_cnt;
        int                 rows_done;
        int                 slot;
        out_item_t          due_results [$];
        int                 mismatches;

        function new();
            mode       = 1'b0;
            half_taps  = 3'd1;
            line_width = 12'd640;
            coef_lo    = '0;
            coef_hi    = '0;
            delta      = 0;
            col_cnt    = 0;
            rows_done  = 0;
            slot       = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [63:0] v);
            case (idx)
                REG_MODE:         mode = v[0];
                REG_HALF_TAPS:    half_taps = v[2:0];
                REG_LINE_WIDTH:   line_width = v[11:0];
                REG_COEF_LOW:     coef_lo = v;
                REG_COEF_HIGH:    coef_hi = v;
                REG_DELTA_OFFSET: delta = longint'($signed(v[31:0]));
                default:          ;
            endcase
        endfunction

        function int width_now();
            int w;
            w = line_width;
            if (w == 0)
                w = 1;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;
            return w;
        endfunction

        function longint coef_of(int k);
            logic [63:0] word;
            logic [15:0] lane;
            word = (k < 4) ? coef_lo : coef_hi;
            lane = word[(k % 4) * 16 +: 16];
            return longint'($signed(lane));
        endfunction

        function longint sample_back(int d, int col);
            return longint'(row_ring[(slot + RING_ROWS - d) % RING_ROWS][col]);
        endfunction

        function int column_for(in_item_t it);
            int c;
            c = it.frame_start ? 0 : col_cnt;
            if (c >= width_now())
                c = width_now() - 1;
            return c;
        endfunction

        // True when this pixel's window would touch a store entry never written.
        function bit reads_blank(in_item_t it);
            int col;
            int d;
            if (it.frame_start)
                return 1'b0;
            col = column_for(it);
            if (rows_done < 2 * half_taps)
                return 1'b0;
            for (d = 1; d <= 2 * half_taps; d++)
                if (!row_ring_set[(slot + RING_ROWS - d) % RING_ROWS][col])
                    return 1'b1;
            return 1'b0;
        endfunction

        function void take_pixel(in_item_t it);
            longint    pix;
            longint    acc;
            longint    below;
            longint    above;
            int        h;
            int        col;
            int        k;
            bit        last;
            out_item_t r;
            pix = longint'(it.pixel_value);
            h   = half_taps;
            if (it.frame_start)
            begin
                col_cnt   = 0;
                rows_done = 0;
                slot      = 0;
            end
            col  = column_for(it);
            last = (col == width_now() - 1);
            if (rows_done >= 2 * h)
            begin
                acc = delta;
                if (mode == 1'b0)
                    acc += coef_of(0) * ((h == 0) ? pix : sample_back(h, col));
                for (k = 1; k <= h; k++)
                begin
                    below = (k == h) ? pix : sample_back(h - k, col);
                    above = sample_back(h + k, col);
                    acc += coef_of(k) * ((mode == 1'b0) ? below + above : below - above);
                end
                r.filtered_value = acc[ACC_BITS-1:0];
                r.out_column     = COL_BITS'(col);
                r.row_last       = last;
                due_results.push_back(r);
            end
            row_ring[slot][col]     = it.pixel_value;
            row_ring_set[slot][col] = 1'b1;
            if (last)
            begin
                col_cnt = 0;
                slot    = (slot + 1) % RING_ROWS;
                if (rows_done < RING_ROWS)
                    rows_done++;
            end
            else
                col_cnt = col + 1;
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result: value %0d column %0d last %0b",
                         $time, got.filtered_value, got.out_column, got.row_last);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.filtered_value !== want.filtered_value)
            begin
                $display("%0t: filtered_value expected %0d actual %0d",
                         $time, want.filtered_value, got.filtered_value);
                mismatches++;
            end
            if (got.out_column !== want.out_column)
            begin
                $display("%0t: out_column expected %0d actual %0d",
                         $time, want.out_column, got.out_column);
                mismatches++;
            end
            if (got.row_last !== want.row_last)
            begin
                $display("%0t: row_last expected %0b actual %0b",
                         $time, want.row_last, got.row_last);
                mismatches++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    in_item_t                    in_item = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    out_item_t                   out_item;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

    column_fir_checker fir_check = new();
    bit                steady = 1'b0;
    int                hold_cycles = 0;
    int                pixels_sent = 0;
    int                cycle_count = 0;

    symmetric_column_fir_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[symmetric_column_fir_filter_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            fir_check.check_result(out_item);

    initial
    begin
        int hold;
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 13);
            if (hold_cycles > 0)
            begin
                hold        = hold_cycles;
                hold_cycles = 0;
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(rst_n && out_valid))
                @(posedge clk);
        end
    end

    function automatic in_item_t make_item(logic signed [15:0] v, bit fs);
        in_item_t it;
        it.pixel_value = v;
        it.frame_start = fs;
        return it;
    endfunction

    function automatic logic signed [15:0] draw_pixel();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] draw_coefs();
        logic [63:0] word;
        int          k;
        for (k = 0; k < 4; k++)
            case ($urandom_range(0, 5))
                0:       word[k*16 +: 16] = 16'h8000;
                1:       word[k*16 +: 16] = 16'h7FFF;
                2:       word[k*16 +: 16] = 16'h0000;
                default: word[k*16 +: 16] = 16'($urandom);
            endcase
        return word;
    endfunction

    function automatic logic [31:0] draw_delta();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pixel(in_item_t it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        fir_check.take_pixel(it);
        pixels_sent++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        fir_check.set_reg(idx, v);
    endtask

    task automatic apply_settings(bit m, int h, int w, logic [63:0] lo, logic [63:0] hi,
                                  logic [31:0] d);
        write_reg(REG_MODE, 64'(m));
        write_reg(REG_HALF_TAPS, 64'(h));
        write_reg(REG_LINE_WIDTH, 64'(w));
        write_reg(REG_COEF_LOW, lo);
        write_reg(REG_COEF_HIGH, hi);
        write_reg(REG_DELTA_OFFSET, {32'h0, d});
        cfg_valid <= 1'b0;
    endtask

    // A pixel may leave no result, so the pipeline is given time to empty as well.
    task automatic drain();
        in_valid <= 1'b0;
        while (fir_check.due_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic random_phase(bit pressure);
        in_item_t it;
        int       count;
        int       w;
        int       h;
        int       i;
        bit       fresh;
        drain();
        if (pressure)
        begin
            h     = 0;
            w     = 6;
            count = 80;
        end
        else
        begin
            h = $urandom_range(0, 7);
            case ($urandom_range(0, 11))
                0:       w = 0;
                1:       w = 1;
                2:       w = MAX_WIDTH;
                3:       w = $urandom_range(MAX_WIDTH + 1, 4095);
                4:       w = $urandom_range(13, 64);
                default: w = $urandom_range(2, 12);
            endcase
            count = $urandom_range(30, 120);
        end
        apply_settings(1'($urandom_range(0, 1)), h, w, draw_coefs(), draw_coefs(),
                       draw_delta());
        steady = pressure || ($urandom_range(0, 4) == 0);
        if (pressure)
            hold_cycles = 300;
        fresh = pressure || $urandom_range(0, 1);
        for (i = 0; i < count; i++)
        begin
            it = make_item(draw_pixel(), (i == 0 && fresh) || $urandom_range(0, 79) == 0
                           || (fir_check.col_cnt == 0 && $urandom_range(0, 19) == 0));
            if (fir_check.reads_blank(it))
                it.frame_start = 1'b1;
            send_pixel(it);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        int                 i;
        int                 phase;
        logic signed [15:0] v;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extreme samples against the most negative centre and most positive pair taps.
        apply_settings(1'b0, 1, 3, 64'h0000_0000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                       32'h8000_0000);
        for (i = 0; i < 13; i++)
        begin
            v = ((i / 3) % 2 == 0) ? 16'sh7FFF : 16'sh8000;
            if (i % 3 == 2)
                v = ((i / 3) % 2 == 0) ? 16'sh0000 : 16'shFFFF;
            send_pixel(make_item(v, i == 0));
        end
        send_pixel(make_item(16'sh7FFF, 1'b1));

        // Antisymmetric with no taps and a zero width: every pixel gives the offset alone.
        drain();
        apply_settings(1'b1, 0, 0, 64'h0000_0000_0000_7FFF, 64'h0, 32'h7FFF_FFFF);
        send_pixel(make_item(16'sh7FFF, 1'b0));
        send_pixel(make_item(16'sh8000, 1'b0));
        send_pixel(make_item(16'sh0000, 1'b1));
        send_pixel(make_item(16'shFFFF, 1'b0));

        // Widest taps and an oversized width, then the width lowered part way along a row.
        drain();
        apply_settings(1'b0, 7, 4095, 64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                       32'h0);
        for (i = 0; i < 4; i++)
            send_pixel(make_item(draw_pixel(), i == 0));
        drain();
        apply_settings(1'b0, 0, 2, 64'h0000_0000_0000_8000, 64'h0, 32'hFFFF_FFFF);
        send_pixel(make_item(16'sh7FFF, 1'b0));
        send_pixel(make_item(16'sh8000, 1'b0));

        phase = 0;
        while (pixels_sent < PIXEL_TARGET)
        begin
            random_phase(phase == 3);
            phase++;
        end

        drain();
        if (fir_check.mismatches == 0)
            $display("[symmetric_column_fir_filter_unit] OK");
        else
            $display("[symmetric_column_fir_filter_unit] ERROR");
        $finish;
    end
endmodule
